// ===== rtl/isr_pkg.sv =====
package isr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_BURST   = 64;
  localparam int TIME_W      = 64;
  localparam int PER_W       = 26;
  localparam int GAP_W       = 30;
  localparam int CFG_W       = 30;
  localparam int NUM_LANES   = 6;
  localparam int PROD_W      = SAMPLE_BITS + GAP_W;
  localparam int CNT_W       = $clog2(MAX_BURST + 1);
  localparam int LSTEP_W     = $clog2(SAMPLE_BITS + 2);
  localparam int SSTEP_W     = $clog2(GAP_W + 1);

  localparam logic [PER_W-1:0] PERIOD_RST = 26'd1000000;
  localparam logic [GAP_W-1:0] GAP_RST    = 30'd50000000;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_GAP    = 1'b1;

  // Lane order follows the remapped axes (a, b, c) = (x, -z, y).
  localparam int LN_GA = 0;
  localparam int LN_GB = 1;
  localparam int LN_GC = 2;
  localparam int LN_AA = 3;
  localparam int LN_AB = 4;
  localparam int LN_AC = 5;

  typedef enum logic [1:0] {
    EV_SAMPLE = 2'd0,
    EV_FIRST  = 2'd1,
    EV_GAP    = 2'd2,
    EV_ORDER  = 2'd3
  } ev_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_EVENT,
    S_TICK,
    S_LANE,
    S_SKIP
  } st_t;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] smp_vec_t;

  typedef struct packed {
    logic             load;
    logic [GAP_W-1:0] num;
    logic [GAP_W-1:0] den;
  } lane_cmd_t;

  typedef struct packed {
    logic             load;
    logic [GAP_W-1:0] dvd;
    logic [PER_W-1:0] dvs;
  } skip_cmd_t;

  typedef struct packed {
    logic push;
    ev_t  ev;
    logic last;
  } mrg_cmd_t;

  // Negation that saturates the most negative code to the most positive one.
  function automatic smp_t neg_sat(input smp_t v);
    if (v == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return -v;
  endfunction

endpackage

// ===== rtl/isr_lane.sv =====
module isr_lane import isr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_cmd_t cmd,
  input  smp_t      prev_smp,
  input  smp_t      cur_smp,
  output logic      done,
  output smp_t      res
);

  localparam logic [LSTEP_W-1:0] LAST_STEP = LSTEP_W'(SAMPLE_BITS + 1);

  logic                    run_r;
  logic                    done_r;
  logic [LSTEP_W-1:0]      step_r;
  logic                    neg_r;
  logic [SAMPLE_BITS-1:0]  mag_r;
  logic [SAMPLE_BITS-1:0]  base_r;
  logic [GAP_W-1:0]        num_r;
  logic [GAP_W-1:0]        den_r;
  logic [PROD_W-1:0]       prod_r;
  logic [GAP_W-1:0]        rem_r;
  logic [SAMPLE_BITS-1:0]  quo_r;
  logic [SAMPLE_BITS-1:0]  res_r;

  logic signed [SAMPLE_BITS:0] diff;
  logic signed [SAMPLE_BITS:0] diff_abs;
  logic [PROD_W:0]             divd;
  logic [GAP_W:0]              trial;
  logic [GAP_W:0]              trial_sub;
  logic                        ge;
  logic [GAP_W-1:0]            rem_nxt;
  logic [SAMPLE_BITS-1:0]      quo_nxt;
  logic [SAMPLE_BITS:0]        base_ext;
  logic [SAMPLE_BITS:0]        q_ext;
  logic [SAMPLE_BITS:0]        sum;

  assign diff     = {cur_smp[SAMPLE_BITS-1], cur_smp} - {prev_smp[SAMPLE_BITS-1], prev_smp};
  assign diff_abs = diff[SAMPLE_BITS] ? -diff : diff;

  // Rounding is folded in by adding half the divisor before the division.
  assign divd = {1'b0, prod_r} + (PROD_W + 1)'(den_r >> 1);

  // One restoring step per cycle; the partial remainder always stays below den.
  assign trial     = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = (trial >= {1'b0, den_r});
  assign rem_nxt   = ge ? trial_sub[GAP_W-1:0] : trial[GAP_W-1:0];
  assign quo_nxt   = {quo_r[SAMPLE_BITS-2:0], ge};

  assign base_ext = {base_r[SAMPLE_BITS-1], base_r};
  assign q_ext    = {1'b0, quo_nxt};
  assign sum      = neg_r ? (base_ext - q_ext) : (base_ext + q_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (cmd.load) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (run_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= diff[SAMPLE_BITS];
      mag_r  <= diff_abs[SAMPLE_BITS-1:0];
      base_r <= prev_smp;
      num_r  <= cmd.num;
      den_r  <= cmd.den;
    end
    if (run_r) begin
      if (step_r == '0) begin
        prod_r <= mag_r * num_r;
      end else if (step_r == LSTEP_W'(1)) begin
        rem_r <= divd[PROD_W-1:SAMPLE_BITS];
        quo_r <= divd[SAMPLE_BITS-1:0];
      end else begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
      end
      if (step_r == LAST_STEP) begin
        res_r <= sum[SAMPLE_BITS-1:0];
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== rtl/isr_skip.sv =====
module isr_skip import isr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  skip_cmd_t        cmd,
  output logic             done,
  output logic [PER_W-1:0] rem
);

  localparam logic [SSTEP_W-1:0] LAST_STEP = SSTEP_W'(GAP_W - 1);

  logic               run_r;
  logic               done_r;
  logic [SSTEP_W-1:0] step_r;
  logic [PER_W-1:0]   rem_r;
  logic [GAP_W-1:0]   sh_r;
  logic [PER_W-1:0]   dvs_r;

  logic [PER_W:0]     trial;
  logic [PER_W:0]     trial_sub;
  logic               ge;
  logic [PER_W-1:0]   rem_nxt;

  assign trial     = {rem_r, sh_r[GAP_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign rem_nxt   = ge ? trial_sub[PER_W-1:0] : trial[PER_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (cmd.load) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (run_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
      sh_r  <= cmd.dvd;
      dvs_r <= cmd.dvs;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[GAP_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/isr_merge.sv =====
module isr_merge import isr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mrg_cmd_t cmd,
  input  smp_vec_t lane_res,
  input  smp_vec_t cur_smp,
  output logic     ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ev_t      out_ev,
  output smp_vec_t out_smp,
  output logic     out_last
);

  logic     vld_r;
  ev_t      ev_r;
  smp_vec_t smp_r;
  logic     last_r;
  smp_vec_t sel;

  // The output register frees up in the same cycle its beat is taken.
  assign ready = !vld_r || out_ready;

  always_comb begin
    case (cmd.ev)
      EV_SAMPLE: sel = lane_res;
      EV_ORDER:  sel = '0;
      default:   sel = cur_smp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.push) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ev_r   <= cmd.ev;
      smp_r  <= sel;
      last_r <= cmd.last;
    end
  end

  assign out_valid = vld_r;
  assign out_ev    = ev_r;
  assign out_smp   = smp_r;
  assign out_last  = last_r;

  ap_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> ready)
    else $error("merge pushed while a beat was still held");

  ap_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && cmd.ev == EV_ORDER) |=> (out_smp == '0 && out_last))
    else $error("out-of-order beat carries sample data");

endmodule

// ===== rtl/imu_sample_clock_resampler.sv =====
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | in_time_ns, in_gyro_x/y/z, in_accel_x/y/z
// out     | out_valid / out_ready | out_event_res, out_gyro_a/b/c, out_accel_a/b/c, out_last
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// A report is taken in idle and sorted in decide; an interpolated sample then
// passes the tick and lane states, the six lane dividers working one quotient bit
// a cycle. A restart or out-of-order report is emitted from the event state in
// place of the final tick check, a negative time is dropped in decide, and hitting the
// 64-sample cap adds the skip state, whose 30-step remainder unit realigns the grid.
// Reset is synchronous and active low; it restores the register defaults and
// clears all clock state. A stalled output holds one beat while the next sample
// is already being computed; a new report is taken only when the last one is done.
module imu_sample_clock_resampler import isr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TIME_W-1:0] in_time_ns,
  input  smp_t                     in_gyro_x,
  input  smp_t                     in_gyro_y,
  input  smp_t                     in_gyro_z,
  input  smp_t                     in_accel_x,
  input  smp_t                     in_accel_y,
  input  smp_t                     in_accel_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_event_res,
  output smp_t                     out_gyro_a,
  output smp_t                     out_gyro_b,
  output smp_t                     out_gyro_c,
  output smp_t                     out_accel_a,
  output smp_t                     out_accel_b,
  output smp_t                     out_accel_c,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  st_t               state_r;
  st_t               state_nxt;
  logic [PER_W-1:0]  period_r;
  logic [GAP_W-1:0]  gap_r;
  logic              started_r;
  logic [TIME_W-2:0] prev_time_r;
  logic [TIME_W-1:0] next_tick_r;
  smp_vec_t          prev_smp_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] cur_t_r;
  smp_vec_t          cur_smp_r;
  ev_t               ev_r;
  logic [GAP_W-1:0]  den_r;

  logic              t_neg;
  logic              t_le_prev;
  logic [TIME_W-2:0] time_diff;
  logic              gap_hit;
  logic [TIME_W-1:0] t_ext;
  logic              tick_due;
  logic              burst_ok;
  logic [PER_W-1:0]  per_eff;
  logic [TIME_W-1:0] per_ext;
  logic [TIME_W-1:0] tick_num_full;
  logic [TIME_W-1:0] skip_full;
  logic [TIME_W-1:0] tick_fix;
  ev_t               decide_ev;

  logic              restart;
  logic              retire;
  logic              advance;
  logic              fix;

  lane_cmd_t         lane_cmd;
  skip_cmd_t         skip_cmd;
  mrg_cmd_t          mrg_cmd;
  logic [NUM_LANES-1:0] lane_done;
  smp_vec_t          lane_res;
  logic              lanes_done;
  logic              skip_done;
  logic [PER_W-1:0]  skip_rem;
  logic              mrg_ready;
  ev_t               mrg_ev;
  smp_vec_t          mrg_smp;

  assign cfg_ready = 1'b1;

  assign t_neg     = cur_t_r[TIME_W-1];
  assign t_le_prev = (cur_t_r[TIME_W-2:0] <= prev_time_r);
  assign time_diff = cur_t_r[TIME_W-2:0] - prev_time_r;
  assign gap_hit   = (time_diff > {{(TIME_W-1-GAP_W){1'b0}}, gap_r});
  assign t_ext     = {1'b0, cur_t_r[TIME_W-2:0]};
  assign tick_due  = (next_tick_r <= t_ext);
  assign burst_ok  = (cnt_r < CNT_W'(MAX_BURST));
  assign per_eff   = (period_r == '0) ? {{(PER_W-1){1'b0}}, 1'b1} : period_r;
  assign per_ext   = {{(TIME_W-PER_W){1'b0}}, per_eff};
  assign tick_num_full = next_tick_r - {1'b0, prev_time_r};
  assign skip_full     = t_ext - next_tick_r;
  // First grid tick past the report time: t - ((t - tick) mod period) + period.
  assign tick_fix  = t_ext - {{(TIME_W-PER_W){1'b0}}, skip_rem} + per_ext;
  assign decide_ev = !started_r ? EV_FIRST : (t_le_prev ? EV_ORDER : EV_GAP);
  assign lanes_done = &lane_done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (t_neg) begin
          state_nxt = S_IDLE;
        end else if (!started_r || t_le_prev || gap_hit) begin
          state_nxt = S_EVENT;
        end else begin
          state_nxt = S_TICK;
        end
      end
      S_EVENT: begin
        if (mrg_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (tick_due && burst_ok) begin
          state_nxt = S_LANE;
        end else if (tick_due) begin
          state_nxt = S_SKIP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LANE: begin
        if (lanes_done && mrg_ready) begin
          state_nxt = S_TICK;
        end
      end
      S_SKIP: begin
        if (skip_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    restart       = 1'b0;
    retire        = 1'b0;
    advance       = 1'b0;
    fix           = 1'b0;
    lane_cmd.load = 1'b0;
    lane_cmd.num  = tick_num_full[GAP_W-1:0];
    lane_cmd.den  = den_r;
    skip_cmd.load = 1'b0;
    skip_cmd.dvd  = skip_full[GAP_W-1:0];
    skip_cmd.dvs  = per_eff;
    mrg_cmd.push  = 1'b0;
    mrg_cmd.ev    = ev_r;
    mrg_cmd.last  = 1'b1;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_DECIDE: begin
        restart = !t_neg && (!started_r || (!t_le_prev && gap_hit));
      end
      S_EVENT: mrg_cmd.push = mrg_ready;
      S_TICK: begin
        if (tick_due && burst_ok) begin
          lane_cmd.load = 1'b1;
          advance       = 1'b1;
        end else begin
          retire        = 1'b1;
          skip_cmd.load = tick_due;
        end
      end
      S_LANE: begin
        // next_tick and the count already point past this sample.
        mrg_cmd.push = lanes_done && mrg_ready;
        mrg_cmd.ev   = EV_SAMPLE;
        mrg_cmd.last = !(tick_due && burst_ok);
      end
      S_SKIP: fix = skip_done;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RST;
      gap_r       <= GAP_RST;
      started_r   <= 1'b0;
      prev_time_r <= '0;
      next_tick_r <= '0;
      prev_smp_r  <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PERIOD: period_r <= cfg_data[PER_W-1:0];
          CFG_GAP:    gap_r    <= cfg_data[GAP_W-1:0];
          default:    period_r <= period_r;
        endcase
      end
      if (state_r == S_DECIDE) begin
        cnt_r <= '0;
      end
      if (restart) begin
        started_r   <= 1'b1;
        next_tick_r <= t_ext + per_ext;
      end
      if (restart || retire) begin
        prev_time_r <= cur_t_r[TIME_W-2:0];
        prev_smp_r  <= cur_smp_r;
      end
      if (advance) begin
        next_tick_r <= next_tick_r + per_ext;
        cnt_r       <= cnt_r + 1'b1;
      end
      if (fix) begin
        next_tick_r <= tick_fix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_t_r          <= in_time_ns;
      cur_smp_r[LN_GA] <= in_gyro_x;
      cur_smp_r[LN_GB] <= neg_sat(in_gyro_z);
      cur_smp_r[LN_GC] <= in_gyro_y;
      cur_smp_r[LN_AA] <= in_accel_x;
      cur_smp_r[LN_AB] <= neg_sat(in_accel_z);
      cur_smp_r[LN_AC] <= in_accel_y;
    end
    if (state_r == S_DECIDE) begin
      ev_r  <= decide_ev;
      den_r <= time_diff[GAP_W-1:0];
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    isr_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (lane_cmd),
      .prev_smp (prev_smp_r[i]),
      .cur_smp  (cur_smp_r[i]),
      .done     (lane_done[i]),
      .res      (lane_res[i])
    );
  end

  isr_skip u_skip (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (skip_cmd),
    .done  (skip_done),
    .rem   (skip_rem)
  );

  isr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (mrg_cmd),
    .lane_res  (lane_res),
    .cur_smp   (cur_smp_r),
    .ready     (mrg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ev    (mrg_ev),
    .out_smp   (mrg_smp),
    .out_last  (out_last)
  );

  assign out_event_res = mrg_ev;
  assign out_gyro_a    = mrg_smp[LN_GA];
  assign out_gyro_b    = mrg_smp[LN_GB];
  assign out_gyro_c    = mrg_smp[LN_GC];
  assign out_accel_a   = mrg_smp[LN_AA];
  assign out_accel_b   = mrg_smp[LN_AB];
  assign out_accel_c   = mrg_smp[LN_AC];

  ap_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> (&lane_done))
    else $error("interpolation lanes finished out of step");

  ap_burst_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BURST))
    else $error("burst count ran past the cap");

  ap_sample_started: assert property (@(posedge clk) disable iff (!rst_n)
    (mrg_cmd.push && mrg_cmd.ev == EV_SAMPLE) |-> started_r)
    else $error("interpolated beat before the clock was started");

  ap_tick_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (started_r && state_r == S_IDLE) |-> (next_tick_r > {1'b0, prev_time_r}))
    else $error("next tick does not lie past the last report");

endmodule

// ===== bench/imu_sample_clock_resampler_tb.sv =====
module imu_sample_clock_resampler_tb import isr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYC_LIMIT  = 4_000_000;
  localparam int HOLD_CYC   = 600;
  localparam int SETTLE_CYC = 120;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_RPTS  = 20;

  localparam smp_t SMP_MIN = smp_t'(-(2 ** (SAMPLE_BITS - 1)));
  localparam smp_t SMP_MAX = smp_t'(2 ** (SAMPLE_BITS - 1) - 1);

  // One IMU report as offered on the input channel; lanes are raw x, y, z.
  typedef struct packed {
    logic [TIME_W-1:0] t;
    smp_t [2:0]        gyro;
    smp_t [2:0]        accel;
  } imu_rpt_t;

  // One resampled beat; lanes are remapped a, b, c.
  typedef struct packed {
    ev_t        ev;
    smp_t [2:0] gyro;
    smp_t [2:0] accel;
    logic       last;
  } resamp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [TIME_W-1:0] in_time_ns = '0;
  smp_t                     in_gyro_x = '0;
  smp_t                     in_gyro_y = '0;
  smp_t                     in_gyro_z = '0;
  smp_t                     in_accel_x = '0;
  smp_t                     in_accel_y = '0;
  smp_t                     in_accel_z = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_event_res;
  smp_t                     out_gyro_a;
  smp_t                     out_gyro_b;
  smp_t                     out_gyro_c;
  smp_t                     out_accel_a;
  smp_t                     out_accel_b;
  smp_t                     out_accel_c;
  logic                     out_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_index = CFG_PERIOD;
  logic [CFG_W-1:0]         cfg_data = '0;

  imu_sample_clock_resampler dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_time_ns   (in_time_ns),
    .in_gyro_x    (in_gyro_x),
    .in_gyro_y    (in_gyro_y),
    .in_gyro_z    (in_gyro_z),
    .in_accel_x   (in_accel_x),
    .in_accel_y   (in_accel_y),
    .in_accel_z   (in_accel_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_event_res(out_event_res),
    .out_gyro_a   (out_gyro_a),
    .out_gyro_b   (out_gyro_b),
    .out_gyro_c   (out_gyro_c),
    .out_accel_a  (out_accel_a),
    .out_accel_b  (out_accel_b),
    .out_accel_c  (out_accel_c),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  imu_rpt_t rpt_pending[$];
  resamp_t  resamp_due[$];

  // Predicted block state and register copies.
  logic [PER_W-1:0]  rs_period = PERIOD_RST;
  logic [GAP_W-1:0]  rs_gap = GAP_RST;
  logic              rs_started = 1'b0;
  logic [TIME_W-1:0] rs_prev_t = '0;
  logic [TIME_W-1:0] rs_next_tick = '0;
  smp_t              rs_prev_g [3] = '{default: '0};
  smp_t              rs_prev_a [3] = '{default: '0};

  // The stimulus side tracks the last time the block will keep.
  logic              gen_started = 1'b0;
  logic [TIME_W-1:0] gen_last_t = '0;

  logic tx_idle_en = 1'b0;
  logic rx_idle_en = 1'b0;
  logic rx_hold_req = 1'b0;

  int rpt_queued = 0;
  int rpt_taken = 0;
  int err_cnt = 0;
  int n_checked = 0;
  int n_ignored = 0;
  int n_sample = 0;
  int n_first = 0;
  int n_gap = 0;
  int n_order = 0;
  int n_capped = 0;
  int n_settings = 0;
  int cyc_cnt = 0;

  function automatic smp_t sat_negate(input smp_t v);
    return (v == SMP_MIN) ? SMP_MAX : -v;
  endfunction

  // Linear interpolation; the step from p is rounded half away from zero.
  function automatic smp_t lerp(input smp_t p, input smp_t c,
                                input logic [63:0] num, input logic [63:0] den);
    longint d, mag, q;
    d = longint'(c) - longint'(p);
    mag = (d < 0) ? -d : d;
    q = (mag * longint'(num) + longint'(den >> 1)) / longint'(den);
    return (d < 0) ? smp_t'(longint'(p) - q) : smp_t'(longint'(p) + q);
  endfunction

  task automatic resample_report(input imu_rpt_t rpt);
    logic [TIME_W-1:0] t, per, den, num, skip_n;
    smp_t    g [3];
    smp_t    a [3];
    resamp_t res;
    int      n;
    t = rpt.t;
    per = (rs_period == '0) ? 64'd1 : 64'(rs_period);
    res = '0;
    n = 0;
    if (t[TIME_W-1]) begin
      n_ignored++;
      return;
    end
    g[0] = rpt.gyro[0];
    g[1] = sat_negate(rpt.gyro[2]);
    g[2] = rpt.gyro[1];
    a[0] = rpt.accel[0];
    a[1] = sat_negate(rpt.accel[2]);
    a[2] = rpt.accel[1];
    if (rs_started && t <= rs_prev_t) begin
      res.ev = EV_ORDER;
      res.last = 1'b1;
      resamp_due.push_back(res);
      n_order++;
      return;
    end
    if (!rs_started || t - rs_prev_t > 64'(rs_gap)) begin
      res.ev = rs_started ? EV_GAP : EV_FIRST;
      for (int i = 0; i < 3; i++) begin
        res.gyro[i] = g[i];
        res.accel[i] = a[i];
      end
      res.last = 1'b1;
      resamp_due.push_back(res);
      if (rs_started) n_gap++;
      else n_first++;
      rs_started = 1'b1;
      rs_next_tick = t + per;
    end else begin
      den = t - rs_prev_t;
      while (rs_next_tick <= t && n < MAX_BURST) begin
        num = rs_next_tick - rs_prev_t;
        res.ev = EV_SAMPLE;
        for (int i = 0; i < 3; i++) begin
          res.gyro[i] = lerp(rs_prev_g[i], g[i], num, den);
          res.accel[i] = lerp(rs_prev_a[i], a[i], num, den);
        end
        res.last = (rs_next_tick + per > t) || (n == MAX_BURST - 1);
        resamp_due.push_back(res);
        n++;
        n_sample++;
        rs_next_tick += per;
      end
      // Ticks past the burst cap are dropped; the grid is kept.
      if (rs_next_tick <= t) begin
        skip_n = (t - rs_next_tick) / per + 64'd1;
        rs_next_tick += skip_n * per;
        n_capped++;
      end
    end
    rs_prev_t = t;
    for (int i = 0; i < 3; i++) begin
      rs_prev_g[i] = g[i];
      rs_prev_a[i] = a[i];
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
             $time, what, n_checked, got, want);
  endtask

  task automatic check_result(input resamp_t got);
    resamp_t want;
    if (resamp_due.size() == 0) begin
      report_mismatch("unexpected beat, event code", longint'(got.ev), -1);
      return;
    end
    want = resamp_due.pop_front();
    n_checked++;
    if (got.ev !== want.ev) report_mismatch("event code", longint'(got.ev), longint'(want.ev));
    for (int i = 0; i < 3; i++) begin
      if (got.gyro[i] !== want.gyro[i]) begin
        report_mismatch($sformatf("gyro lane %0d", i), longint'(got.gyro[i]),
                        longint'(want.gyro[i]));
      end
      if (got.accel[i] !== want.accel[i]) begin
        report_mismatch($sformatf("accel lane %0d", i), longint'(got.accel[i]),
                        longint'(want.accel[i]));
      end
    end
    if (got.last !== want.last) begin
      report_mismatch("last flag", longint'(got.last), longint'(want.last));
    end
  endtask

  function automatic int draw_idle(input logic en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic smp_t rand_smp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return SMP_MIN;
    if (r < 16) return SMP_MAX;
    return smp_t'($urandom);
  endfunction

  // Input driver: one report per beat, with random gaps between beats.
  imu_rpt_t tx_cur = '0;
  int       tx_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        resample_report(tx_cur);
        rpt_taken++;
        tx_wait = draw_idle(tx_idle_en);
      end
      if (in_valid && !in_ready) begin
        // Beat still offered; payload holds.
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (rpt_pending.size() > 0) begin
        tx_cur = rpt_pending.pop_front();
        in_valid <= 1'b1;
        in_time_ns <= tx_cur.t;
        in_gyro_x <= tx_cur.gyro[0];
        in_gyro_y <= tx_cur.gyro[1];
        in_gyro_z <= tx_cur.gyro[2];
        in_accel_x <= tx_cur.accel[0];
        in_accel_y <= tx_cur.accel[1];
        in_accel_z <= tx_cur.accel[2];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor with random back-pressure and one long hold-off.
  int   rx_wait = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(resamp_t'({out_event_res, out_gyro_c, out_gyro_b, out_gyro_a,
                                out_accel_c, out_accel_b, out_accel_a, out_last}));
        rx_wait = draw_idle(rx_idle_en);
      end
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("Timeout after %0d cycles", cyc_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_report(input logic [TIME_W-1:0] t, input smp_t gx, input smp_t gy,
                              input smp_t gz, input smp_t ax, input smp_t ay, input smp_t az);
    imu_rpt_t rpt;
    rpt.t = t;
    rpt.gyro[0] = gx;
    rpt.gyro[1] = gy;
    rpt.gyro[2] = gz;
    rpt.accel[0] = ax;
    rpt.accel[1] = ay;
    rpt.accel[2] = az;
    rpt_pending.push_back(rpt);
    rpt_queued++;
    if (!t[TIME_W-1] && !(gen_started && t <= gen_last_t)) begin
      gen_started = 1'b1;
      gen_last_t = t;
    end
  endtask

  task automatic queue_random(input int n);
    logic [TIME_W-1:0] t, per, gapl, dt;
    int made, pick, r2;
    made = 0;
    while (made < n) begin
      per = (rs_period == '0) ? 64'd1 : 64'(rs_period);
      gapl = 64'(rs_gap);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        t = {1'b1, 63'({$urandom, $urandom})};
      end else if (pick < 9) begin
        t = gen_last_t - (64'($urandom_range(0, 1000)) % (gen_last_t + 64'd1));
      end else if (pick < 14) begin
        t = gen_last_t + gapl + 64'd1 + 64'($urandom_range(0, 1000));
      end else if (pick < 18) begin
        // Aim past the burst cap where the gap limit allows it.
        dt = 64'(MAX_BURST) * per + 64'($urandom_range(0, 32'(2 * per)));
        if (dt > gapl) dt = gapl;
        if (dt == 0) dt = 64'd1;
        t = gen_last_t + dt;
      end else if (pick < 21) begin
        t = {2'b00, 62'({$urandom, $urandom})};
      end else begin
        r2 = $urandom_range(0, 9);
        if (r2 < 2) dt = 64'($urandom_range(1, (per > 1) ? 32'(per - 1) : 1));
        else if (r2 < 3) dt = per * 64'($urandom_range(1, 3));
        else dt = 64'($urandom_range(1, 32'(3 * per)));
        if (gapl != 0 && dt > gapl) dt = gapl;
        t = gen_last_t + dt;
      end
      if (!t[TIME_W-1]) made++;
      queue_report(t, rand_smp(), rand_smp(), rand_smp(), rand_smp(), rand_smp(), rand_smp());
    end
  endtask

  // Waits until every report is taken and every beat has come, then lets
  // any report that produces no beat finish inside the block.
  task automatic drain_block();
    while (rpt_taken != rpt_queued || resamp_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PERIOD) rs_period = val[PER_W-1:0];
    else rs_gap = val[GAP_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] per_v, input logic [CFG_W-1:0] gap_v);
    write_reg(CFG_PERIOD, per_v);
    write_reg(CFG_GAP, gap_v);
    n_settings++;
  endtask

  initial begin
    longint per_v, gap_v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: negative time, first report, out-of-order, no tick due,
    // rounding ties, a spacing of exactly the gap limit, and a gap restart.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    queue_report(64'h8000_0000_0000_0000, 1, 2, 3, 4, 5, 6);
    queue_report(64'd0, SMP_MAX, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MAX, SMP_MAX);
    queue_report(64'd0, 7, 7, 7, 7, 7, 7);
    queue_report(64'd500_000, 0, 0, 0, 0, 0, 0);
    queue_report(64'd1_500_000, 1, -3, 1, SMP_MAX, SMP_MIN, SMP_MIN);
    queue_report(gen_last_t + 64'd50_000_000, SMP_MIN, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MIN,
                 SMP_MIN);
    queue_report(gen_last_t + 64'd50_000_001, -5, 9, -100, 300, -7, 2);
    queue_report(gen_last_t + 64'd999_999, 11, -12, 13, -14, 15, -16);
    queue_report(gen_last_t + 64'd3_000_000, rand_smp(), rand_smp(), rand_smp(),
                 rand_smp(), rand_smp(), rand_smp());
    drain_block();

    // Shortest period: a capped burst with skipped ticks, exactly a full burst,
    // one tick over the cap, and a restart.
    set_config(1, 1000);
    queue_report(gen_last_t + 64'd1000, 100, -100, 200, -200, 300, -300);
    queue_report(gen_last_t + 64'd1, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX);
    queue_report(gen_last_t + 64'd64, 5, 6, 7, 8, 9, 10);
    queue_report(gen_last_t + 64'd65, -5, -6, -7, -8, -9, -10);
    queue_report(gen_last_t + 64'd1001, 1, 1, 1, 1, 1, 1);
    drain_block();

    // Zero period runs as one; a zero gap limit restarts each in-order report.
    set_config(0, 0);
    queue_report(gen_last_t + 64'd1, 2, 3, 4, 5, 6, 7);
    queue_report(gen_last_t + 64'd7, -2, -3, -4, -5, -6, -7);
    queue_report(gen_last_t, 0, 0, 0, 0, 0, 0);
    queue_random(4);
    drain_block();

    // The receiver stalls for a long stretch while the sender keeps offering.
    set_config(1000, 200_000);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    for (int i = 0; i < 20; i++) begin
      queue_report(gen_last_t + 64'($urandom_range(1500, 3500)), rand_smp(), rand_smp(),
                   rand_smp(), rand_smp(), rand_smp(), rand_smp());
    end
    rx_hold_req = 1'b1;
    drain_block();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      per_v = $urandom_range(1, 1 << $urandom_range(1, 25));
      if ($urandom_range(0, 99) < 60) gap_v = per_v * $urandom_range(2, 80);
      else gap_v = $urandom_range(1, 1_000_000_000);
      if (gap_v > 1_000_000_000) gap_v = 1_000_000_000;
      set_config(CFG_W'(per_v), CFG_W'(gap_v));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      queue_random(PHASE_RPTS);
      drain_block();
    end

    // Largest settings, then the latest possible time closes the run.
    set_config(50_000_000, 1_000_000_000);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    queue_random(PHASE_RPTS);
    queue_report(64'h7FFF_FFFF_FFFF_FFFF, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN,
                 SMP_MIN);
    queue_report(64'h7FFF_FFFF_FFFF_FFFF, 3, 3, 3, 3, 3, 3);
    queue_report(64'hFFFF_FFFF_FFFF_FFFF, -1, -1, -1, -1, -1, -1);
    drain_block();

    $display("Run covered %0d reports (%0d with negative time) over %0d register settings;",
             rpt_taken, n_ignored, n_settings);
    $display("%0d beats checked: %0d interpolated, %0d first, %0d gap, %0d out-of-order; %0d capped.",
             n_checked, n_sample, n_first, n_gap, n_order, n_capped);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/isr_pkg.sv
rtl/isr_lane.sv
rtl/isr_skip.sv
rtl/isr_merge.sv
rtl/imu_sample_clock_resampler.sv
bench/imu_sample_clock_resampler_tb.sv
